[design/vref_pkg.sv]
// Shared types and constants for the vector refraction pipeline.
package vref_pkg;

	// Q2.14 direction component and 32-bit saturated intermediate
	typedef logic signed [15:0] fx_t;
	typedef logic signed [31:0] acc_t;
	typedef logic        [31:0] len_t;

	// quotient bits below the saturation point of a 16-bit result
	localparam int unsigned QBITS = 15;

	localparam fx_t FX_MAX = 16'sh7FFF;
	localparam fx_t FX_MIN = 16'sh8000;

	// data that rides alongside the first square root
	typedef struct packed {
		logic             pos;
		acc_t [2:0]       drs;
		fx_t  [2:0]       nrm;
	} sq1_side_t;

	// data that rides alongside the length square root
	typedef struct packed {
		logic             pos;
		acc_t [2:0]       vec;
	} sq2_side_t;

	// control that rides alongside the divider
	typedef struct packed {
		logic             pos;
		logic             zl;
		logic [2:0]       neg;
		logic [2:0]       ovf;
		len_t             len;
	} div_side_t;

endpackage

[design/vector_refraction.sv]
// Snell refraction of a ray direction: pipelined top level.
//
// Input channel (in_valid/in_ready) takes an incident direction, a surface
// normal and an index ratio, all Q2.14 (ratio unsigned). Output channel
// (out_valid/out_ready) returns the normalized refracted direction and the
// refracts flag; on total internal reflection the direction is zero and the
// flag is clear. One result per transaction, in order.
// The pipeline is six arithmetic stages, the root of k (one bit per stage),
// four stages to build the vector, a 32-stage root for its length, two
// setup stages, a 15-stage restoring divider and the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// every stage is one multiplier or one wide add and compare.
// Reset clears all stage valid bits; the pipeline comes up empty.
// When the receiver stalls with a result in the output register, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated. Empty
// output register lets the pipeline advance regardless of out_ready.
module vector_refraction
	import vref_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] incident_x,
	input  logic signed [15:0] incident_y,
	input  logic signed [15:0] incident_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic        [15:0] index_ratio,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] refracted_x,
	output logic signed [15:0] refracted_y,
	output logic signed [15:0] refracted_z,
	output logic               refracts
);

	localparam logic signed [63:0] ONE_FX  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF_FX = 64'sd1 <<< (FRAC_BITS - 1);
	localparam int SQ1_W  = (31 + FRAC_BITS + 1) / 2;
	localparam int SQ1_RW = 2 * SQ1_W;
	localparam int NS_W   = SQ1_W + 17;
	localparam int SQ2_W  = 32;

	// saturate to the 32-bit signed range
	function automatic acc_t sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	// drop a product back to FRAC_BITS fraction bits, round half up
	function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
		return (x + HALF_FX) >>> FRAC_BITS;
	endfunction

	logic adv;

	fx_t inc_in [3];
	fx_t nrm_in [3];

	assign inc_in[0] = incident_x;
	assign inc_in[1] = incident_y;
	assign inc_in[2] = incident_z;
	assign nrm_in[0] = normal_x;
	assign nrm_in[1] = normal_y;
	assign nrm_in[2] = normal_z;

	// whole pipeline moves when the output register is free or drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage registers
	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                    vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic [SQ1_W-1:0]        vld1_s;
	logic [SQ2_W-1:0]        vld2_s;
	logic [QBITS-1:0]        dvld_s;

	acc_t                    dot_s1 [3];
	logic [31:0]             rr_s1;
	fx_t                     inc_s1 [3];
	fx_t                     nrm_s1 [3];
	logic [15:0]             ratio_s1;

	acc_t                    c_s2;
	acc_t                    r2_s2;
	fx_t                     inc_s2 [3];
	fx_t                     nrm_s2 [3];
	logic [15:0]             ratio_s2;

	logic signed [63:0]      cc_s3;
	logic signed [47:0]      nc_s3 [3];
	acc_t                    r2_s3;
	fx_t                     inc_s3 [3];
	fx_t                     nrm_s3 [3];
	logic [15:0]             ratio_s3;

	acc_t                    t_s4;
	acc_t                    d_s4 [3];
	acc_t                    r2_s4;
	fx_t                     nrm_s4 [3];
	logic [15:0]             ratio_s4;

	logic signed [63:0]      rt_s5;
	logic signed [48:0]      dr_s5 [3];
	fx_t                     nrm_s5 [3];

	acc_t                    k_s6;
	logic                    pos_s6;
	acc_t                    drs_s6 [3];
	fx_t                     nrm_s6 [3];

	sq1_side_t               side1_s [SQ1_W];
	logic [SQ1_RW-1:0]       sq1_rad;
	logic [SQ1_W-1:0]        sq1_root;

	logic signed [NS_W-1:0]  ns_s7 [3];
	acc_t                    drs_s7 [3];
	logic                    pos_s7;

	acc_t                    vec_s8 [3];
	logic                    pos_s8;

	logic signed [63:0]      sq_s9 [3];
	acc_t                    vec_s9 [3];
	logic                    pos_s9;

	logic [63:0]             len2_s10;
	sq2_side_t               side10_s10;

	sq2_side_t               side2_s [SQ2_W];
	logic [SQ2_W-1:0]        sq2_root;

	logic [63:0]             num_s11 [3];
	logic [2:0]              neg_s11;
	len_t                    len_s11;
	logic                    pos_s11;
	logic                    zl_s11;

	logic [63:0]             rem_s12 [3];
	div_side_t               dside_s12;

	logic [63:0]             rem_d [QBITS][3];
	logic [QBITS-1:0]        quo_d [QBITS][3];
	div_side_t               dside_d [QBITS];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld1_s  <= '0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld2_s  <= '0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			dvld_s  <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld1_s  <= {vld1_s[SQ1_W-2:0], vld_s6};
			vld_s7  <= vld1_s[SQ1_W-1];
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld2_s  <= {vld2_s[SQ2_W-2:0], vld_s10};
			vld_s11 <= vld2_s[SQ2_W-1];
			vld_s12 <= vld_s11;
			dvld_s  <= {dvld_s[QBITS-2:0], vld_s12};
			out_valid <= dvld_s[QBITS-1];
		end
	end

	// stages 1 to 6: dot product, k and the tangential term
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dot_s1[i] <= inc_in[i] * nrm_in[i];
				inc_s1[i] <= inc_in[i];
				nrm_s1[i] <= nrm_in[i];
			end
			rr_s1    <= index_ratio * index_ratio;
			ratio_s1 <= index_ratio;

			c_s2     <= sat32(rnd(64'(dot_s1[0]) + 64'(dot_s1[1]) + 64'(dot_s1[2])));
			r2_s2    <= sat32(rnd($signed({32'd0, rr_s1})));
			inc_s2   <= inc_s1;
			nrm_s2   <= nrm_s1;
			ratio_s2 <= ratio_s1;

			cc_s3 <= c_s2 * c_s2;
			for (int i = 0; i < 3; i++)
				nc_s3[i] <= nrm_s2[i] * c_s2;
			r2_s3    <= r2_s2;
			inc_s3   <= inc_s2;
			nrm_s3   <= nrm_s2;
			ratio_s3 <= ratio_s2;

			t_s4 <= sat32(ONE_FX - 64'(sat32(rnd(cc_s3))));
			for (int i = 0; i < 3; i++)
				d_s4[i] <= sat32(64'(inc_s3[i]) - 64'(sat32(rnd(64'(nc_s3[i])))));
			r2_s4    <= r2_s3;
			nrm_s4   <= nrm_s3;
			ratio_s4 <= ratio_s3;

			rt_s5 <= r2_s4 * t_s4;
			for (int i = 0; i < 3; i++)
				dr_s5[i] <= d_s4[i] * $signed({1'b0, ratio_s4});
			nrm_s5 <= nrm_s4;

			k_s6   <= sat32(ONE_FX - 64'(sat32(rnd(rt_s5))));
			pos_s6 <= sat32(ONE_FX - 64'(sat32(rnd(rt_s5)))) > 32'sd0;
			for (int i = 0; i < 3; i++)
				drs_s6[i] <= sat32(rnd(64'(dr_s5[i])));
			nrm_s6 <= nrm_s5;
		end
	end

	// root of k scaled by 2^FRAC_BITS; zero feeds it on reflection
	assign sq1_rad = pos_s6 ? (SQ1_RW'(k_s6[30:0]) << FRAC_BITS) : '0;

	vref_isqrt #(
		.W (SQ1_W)
	) u_sqrt_k (
		.clk  (clk),
		.adv  (adv),
		.rad  (sq1_rad),
		.root (sq1_root)
	);

	// carry the side data alongside the root of k
	always_ff @(posedge clk) begin
		if (adv) begin
			side1_s[0].pos <= pos_s6;
			for (int i = 0; i < 3; i++) begin
				side1_s[0].drs[i] <= drs_s6[i];
				side1_s[0].nrm[i] <= nrm_s6[i];
			end
			for (int j = 1; j < SQ1_W; j++)
				side1_s[j] <= side1_s[j-1];
		end
	end

	// stages 7 to 10: refracted vector and its squared length
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ns_s7[i]  <= side1_s[SQ1_W-1].nrm[i] * $signed({1'b0, sq1_root});
				drs_s7[i] <= side1_s[SQ1_W-1].drs[i];
			end
			pos_s7 <= side1_s[SQ1_W-1].pos;

			for (int i = 0; i < 3; i++)
				vec_s8[i] <= sat32(64'(drs_s7[i]) - 64'(sat32(rnd(64'(ns_s7[i])))));
			pos_s8 <= pos_s7;

			for (int i = 0; i < 3; i++) begin
				sq_s9[i]  <= vec_s8[i] * vec_s8[i];
				vec_s9[i] <= vec_s8[i];
			end
			pos_s9 <= pos_s8;

			len2_s10       <= $unsigned(sq_s9[0]) + $unsigned(sq_s9[1]) + $unsigned(sq_s9[2]);
			side10_s10.pos <= pos_s9;
			for (int i = 0; i < 3; i++)
				side10_s10.vec[i] <= vec_s9[i];
		end
	end

	vref_isqrt #(
		.W (SQ2_W)
	) u_sqrt_len (
		.clk  (clk),
		.adv  (adv),
		.rad  (len2_s10),
		.root (sq2_root)
	);

	// carry the vector alongside the length root
	always_ff @(posedge clk) begin
		if (adv) begin
			side2_s[0] <= side10_s10;
			for (int j = 1; j < SQ2_W; j++)
				side2_s[j] <= side2_s[j-1];
		end
	end

	// stages 11 and 12: rounded dividend and saturation check
	always_ff @(posedge clk) begin
		logic [31:0] mag;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mag = side2_s[SQ2_W-1].vec[i][31] ? 32'(-side2_s[SQ2_W-1].vec[i])
				                                  : side2_s[SQ2_W-1].vec[i];
				num_s11[i] <= (64'(mag) << FRAC_BITS) + 64'(sq2_root >> 1);
				neg_s11[i] <= side2_s[SQ2_W-1].vec[i][31];
			end
			len_s11 <= sq2_root;
			pos_s11 <= side2_s[SQ2_W-1].pos;
			zl_s11  <= (sq2_root == '0);

			for (int i = 0; i < 3; i++) begin
				rem_s12[i]       <= num_s11[i];
				dside_s12.ovf[i] <= num_s11[i] >= (64'(len_s11) << QBITS);
			end
			dside_s12.neg <= neg_s11;
			dside_s12.len <= len_s11;
			dside_s12.pos <= pos_s11;
			dside_s12.zl  <= zl_s11;
		end
	end

	// restoring divider, one quotient bit per stage
	generate
		for (genvar j = 0; j < QBITS; j++) begin : g_div
			localparam int SH = QBITS - 1 - j;
			logic [63:0]      rem_in [3];
			logic [QBITS-1:0] quo_in [3];
			div_side_t        side_in;
			logic [63:0]      rem_nx [3];
			logic [QBITS-1:0] quo_nx [3];

			if (j == 0) begin : g_first
				assign rem_in  = rem_s12;
				assign quo_in  = '{default: '0};
				assign side_in = dside_s12;
			end else begin : g_next
				assign rem_in  = rem_d[j-1];
				assign quo_in  = quo_d[j-1];
				assign side_in = dside_d[j-1];
			end

			always_comb begin
				logic [63:0] dsh;
				dsh = 64'(side_in.len) << SH;
				for (int i = 0; i < 3; i++) begin
					quo_nx[i] = quo_in[i];
					if (rem_in[i] >= dsh) begin
						rem_nx[i]     = rem_in[i] - dsh;
						quo_nx[i][SH] = 1'b1;
					end else begin
						rem_nx[i] = rem_in[i];
					end
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_d[j]   <= rem_nx;
					quo_d[j]   <= quo_nx;
					dside_d[j] <= side_in;
				end
			end
		end
	endgenerate

	// output register: sign, saturation and the zero cases
	always_ff @(posedge clk) begin
		fx_t res [3];
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (!dside_d[QBITS-1].pos || dside_d[QBITS-1].zl)
					res[i] = '0;
				else if (dside_d[QBITS-1].ovf[i])
					res[i] = dside_d[QBITS-1].neg[i] ? FX_MIN : FX_MAX;
				else if (dside_d[QBITS-1].neg[i])
					res[i] = -fx_t'({1'b0, quo_d[QBITS-1][i]});
				else
					res[i] = fx_t'({1'b0, quo_d[QBITS-1][i]});
			end
			refracted_x <= res[0];
			refracted_y <= res[1];
			refracted_z <= res[2];
			refracts    <= dside_d[QBITS-1].pos;
		end
	end

	// reflection gives a zero direction
	a_tir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !refracts |-> refracted_x == '0 && refracted_y == '0 && refracted_z == '0)
		else $error("nonzero direction on total internal reflection");

	// a positive k always has a nonzero root
	a_root_k: assert property (@(posedge clk) disable iff (!arst_n)
		vld1_s[SQ1_W-1] && side1_s[SQ1_W-1].pos |-> sq1_root != '0)
		else $error("zero root for positive k");

	// a zero length only comes from a zero vector
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s11 && pos_s11 && zl_s11 |->
			num_s11[0] == '0 && num_s11[1] == '0 && num_s11[2] == '0)
		else $error("zero length for a nonzero vector");

	// divider leaves a remainder below the length
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_s[QBITS-1] && dside_d[QBITS-1].pos && !dside_d[QBITS-1].zl &&
		dside_d[QBITS-1].ovf == 3'b000 |->
			rem_d[QBITS-1][0] < 64'(dside_d[QBITS-1].len) &&
			rem_d[QBITS-1][1] < 64'(dside_d[QBITS-1].len) &&
			rem_d[QBITS-1][2] < 64'(dside_d[QBITS-1].len))
		else $error("divider remainder not below the length");

endmodule

[design/vref_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
module vref_isqrt #(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           adv,
	input  logic [2*W-1:0] rad,
	output logic [W-1:0]   root
);

	localparam int RW = 2 * W;

	logic [RW-1:0] rem_s [W];
	logic [RW-1:0] acc_s [W];

	generate
		for (genvar i = 0; i < W; i++) begin : g_step
			localparam logic [RW-1:0] STEP = RW'(1) << (2 * (W - 1 - i));
			logic [RW-1:0] rem_in;
			logic [RW-1:0] acc_in;
			logic [RW-1:0] rem_nx;
			logic [RW-1:0] acc_nx;
			logic [RW:0]   trial;

			if (i == 0) begin : g_first
				assign rem_in = rad;
				assign acc_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[i-1];
				assign acc_in = acc_s[i-1];
			end

			// try the next root bit, keep it if the remainder allows
			always_comb begin
				trial = {1'b0, acc_in} + {1'b0, STEP};
				if ({1'b0, rem_in} >= trial) begin
					rem_nx = rem_in - trial[RW-1:0];
					acc_nx = (acc_in >> 1) + STEP;
				end else begin
					rem_nx = rem_in;
					acc_nx = acc_in >> 1;
				end
			end

			// advance the stage
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= rem_nx;
					acc_s[i] <= acc_nx;
				end
			end
		end
	endgenerate

	assign root = acc_s[W-1][W-1:0];

endmodule

[tb/sv/vref_checker.sv]
// Checker for the refraction block: watches both channels, predicts and compares.
module vref_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] incident_x,
	input  logic signed [15:0] incident_y,
	input  logic signed [15:0] incident_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic        [15:0] index_ratio,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] refracted_x,
	input  logic signed [15:0] refracted_y,
	input  logic signed [15:0] refracted_z,
	input  logic               refracts,
	output int                 fail_count,
	output int                 pending,
	output int                 tir_seen,
	output int                 ray_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 14;
	localparam longint ONE = longint'(1) << FB;
	localparam longint HALF = longint'(1) << (FB - 1);

	typedef struct {
		logic signed [15:0] x, y, z;
		logic               ok;
	} ray_t;

	ray_t expected_rays[$];

	function automatic longint clip32(longint a);
		if (a > 64'sd2147483647) return 64'sd2147483647;
		if (a < -64'sd2147483648) return -64'sd2147483648;
		return a;
	endfunction

	// round a double-precision product back to FB fraction bits, half up
	function automatic longint fix_round(longint a);
		return (a + HALF) >>> FB;
	endfunction

	function automatic longint unsigned int_root(longint unsigned a);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > a) b = b >> 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a = a - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic ray_t refract(longint ix, longint iy, longint iz,
			longint nx, longint ny, longint nz, longint ratio);
		ray_t res;
		longint inc[3], nrm[3], v[3];
		longint c, c2, t, r2, q, k, s, d, m;
		longint unsigned len2, len, mag, qq;
		inc[0] = ix; inc[1] = iy; inc[2] = iz;
		nrm[0] = nx; nrm[1] = ny; nrm[2] = nz;
		res.x = 0; res.y = 0; res.z = 0; res.ok = 0;
		c = clip32(fix_round(ix * nx + iy * ny + iz * nz));
		c2 = clip32(fix_round(c * c));
		t = clip32(ONE - c2);
		r2 = clip32(fix_round(ratio * ratio));
		q = clip32(fix_round(r2 * t));
		k = clip32(ONE - q);
		if (k <= 0) return res;
		s = longint'(int_root(longint'(k) << FB));
		len2 = 0;
		for (int i = 0; i < 3; i++) begin
			d = clip32(inc[i] - clip32(fix_round(nrm[i] * c)));
			v[i] = clip32(clip32(fix_round(d * ratio)) - clip32(fix_round(nrm[i] * s)));
			len2 = len2 + longint'(v[i] * v[i]);
		end
		res.ok = 1;
		len = int_root(len2);
		if (len == 0) return res;
		for (int i = 0; i < 3; i++) begin
			mag = longint'(v[i] < 0 ? -v[i] : v[i]) << FB;
			qq = (mag + len / 2) / len;
			m = (qq > 65536) ? 65536 : longint'(qq);
			if (v[i] < 0) m = -m;
			if (m > 32767) m = 32767;
			if (m < -32768) m = -32768;
			if (i == 0) res.x = m[15:0];
			else if (i == 1) res.y = m[15:0];
			else res.z = m[15:0];
		end
		return res;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		ray_t exp_ray;
		if (!arst_n) begin
			fail_count <= 0;
			tir_seen <= 0;
			ray_seen <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_rays.push_back(refract(incident_x, incident_y, incident_z,
					normal_x, normal_y, normal_z, longint'(index_ratio)));
			if (out_valid && out_ready) begin
				ray_seen <= ray_seen + 1;
				if (!refracts) tir_seen <= tir_seen + 1;
				if (expected_rays.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result %0d %0d %0d ok=%0b",
							refracted_x, refracted_y, refracted_z, refracts);
					fail_count <= fail_count + 1;
				end else begin
					exp_ray = expected_rays.pop_front();
					if (exp_ray.x !== refracted_x || exp_ray.y !== refracted_y ||
							exp_ray.z !== refracted_z || exp_ray.ok !== refracts) begin
						if (fail_count < 10)
							$display("ERROR: expected %0d %0d %0d ok=%0b, got %0d %0d %0d ok=%0b",
								exp_ray.x, exp_ray.y, exp_ray.z, exp_ray.ok,
								refracted_x, refracted_y, refracted_z, refracts);
						fail_count <= fail_count + 1;
					end
				end
			end
			// track transactions still in flight
			pending <= expected_rays.size();
		end
	end
endmodule

[tb/sv/tb.sv]
// Testbench top for the refraction block: stimulus, clock, reset and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_RAYS = 1330;
	localparam int LATENCY = 83;
	localparam longint CYCLE_LIMIT = 600000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] incident_x = 0, incident_y = 0, incident_z = 0;
	logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
	logic [15:0] index_ratio = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] refracted_x, refracted_y, refracted_z;
	logic refracts;
	int fail_count, pending, tir_seen, ray_seen;
	longint cycles = 0;
	bit hold_off = 0;

	vector_refraction u_dut (.*);

	vref_checker u_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk) cycles <= cycles + 1;

	// end the run if it hangs
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// random receiver stalls, with one long hold-off to fill the pipeline
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
			end else if (out_ready && out_valid) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
				if (gap != 0) begin
					out_ready <= 0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		hold_off = 1;
		repeat (300) @(posedge clk);
		hold_off = 0;
	end

	// offer one transaction and wait for its acceptance
	task automatic send_ray(logic [15:0] ix, iy, iz, nx, ny, nz, ratio, int gap);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		incident_x <= ix; incident_y <= iy; incident_z <= iz;
		normal_x <= nx; normal_y <= ny; normal_z <= nz;
		index_ratio <= ratio;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [15:0] jitter(logic [15:0] base);
		return base + 16'($urandom_range(0, 600)) - 16'd300;
	endfunction

	initial begin
		int gap, mode;
		logic [15:0] f[7];
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: head-on, glancing, total reflection, zero normal, extremes
		send_ray(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 0);
		send_ray(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h2AAB, 0);
		send_ray(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 0);
		send_ray(16'h3FFF, 16'h0000, 16'hFF00, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 0);
		send_ray(16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 0);
		send_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0);
		send_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1);
		send_ray(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 2);
		send_ray(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 0);
		send_ray(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 0);
		send_ray(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h8000, 0);
		// random: mostly near-unit geometry, some raw noise
		for (int n = 0; n < RANDOM_RAYS; n++) begin
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				f[0] = jitter(16'($urandom_range(0, 1) ? 16'h2D41 : 16'hD2BF));
				f[1] = jitter(16'($urandom_range(0, 16384)) - 16'd8192);
				f[2] = jitter(16'hD2BF);
				f[3] = jitter(16'($urandom_range(0, 4096)) - 16'd2048);
				f[4] = jitter(16'($urandom_range(0, 4096)) - 16'd2048);
				f[5] = jitter(16'h3F00);
				f[6] = 16'($urandom_range(8000, 40000));
			end else begin
				for (int j = 0; j < 7; j++) f[j] = 16'($urandom);
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			if (n % 200 < 40) gap = 0;
			send_ray(f[0], f[1], f[2], f[3], f[4], f[5], f[6], gap);
		end
		in_valid <= 0;
		// drain, then watch a while longer for stray results
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("Ran %0d rays through the pipeline, %0d of them total reflection,",
			ray_seen, tir_seen);
		$display("with random stalls on both sides and one long receiver hold-off.");
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
